### rtl/core/dcpg_pkg.sv
package dcpg_pkg;

    // Default width of the number field.
    localparam int NUMBER_WIDTH_DEF = 20;

    // Divisor count field.
    localparam int COUNT_W = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
    localparam logic [COUNT_W-1:0] PRIME_COUNT = 8'd2;

    // Quotient bits that the remainder unit resolves in one cycle.
    localparam int BITS_PER_CYCLE = 4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // take a new number and restart the trial divisor
        logic start_rem;     // start a remainder of number by the trial divisor
        logic trial_update;  // fold the finished trial into the count, advance divisor
        logic out_load;      // move the finished count into the output register
    } dcpg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sq_le_n;       // square of the trial divisor is not above the number
        logic rem_done;      // remainder unit has a result
    } dcpg_status_t;

endpackage

### rtl/core/dcpg_rem.sv
module dcpg_rem
    import dcpg_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [NUMBER_WIDTH-1:0] dividend,
    input  logic [NUMBER_WIDTH-1:0] divisor,
    output logic                    done,
    output logic                    rem_zero
);

    localparam int ITER = (NUMBER_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
    localparam int PADW = ITER * BITS_PER_CYCLE;
    localparam int CW   = (ITER > 1) ? $clog2(ITER) : 1;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CW-1:0]           step_reg, step_next;
    logic [PADW-1:0]         dvd_reg, dvd_next;
    logic [NUMBER_WIDTH-1:0] d_reg, d_next;
    logic [NUMBER_WIDTH-1:0] r_reg, r_next;
    logic                    last_step;

    // Restoring long division, several quotient bits per cycle; only the
    // remainder is kept.
    always_comb
    begin
        logic [NUMBER_WIDTH:0]   t;
        logic [NUMBER_WIDTH-1:0] r_work;
        logic [PADW-1:0]         dvd_work;
        r_work   = r_reg;
        dvd_work = dvd_reg;
        for (int k = 0; k < BITS_PER_CYCLE; k++)
        begin
            t        = {r_work, dvd_work[PADW-1]};
            dvd_work = {dvd_work[PADW-2:0], 1'b0};
            if (t >= {1'b0, d_reg})
            begin
                t = t - {1'b0, d_reg};
            end
            r_work = t[NUMBER_WIDTH-1:0];
        end

        last_step = busy_reg && (step_reg == CW'(ITER - 1));
        busy_next = busy_reg;
        done_next = last_step;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = '0;
            dvd_next  = PADW'(dividend);
            d_next    = divisor;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            dvd_next  = dvd_work;
            r_next    = r_work;
            step_next = step_reg + CW'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        d_reg   <= d_next;
        r_reg   <= r_next;
    end

    assign done     = done_reg;
    assign rem_zero = (r_reg == '0);

endmodule

### rtl/core/dcpg_datapath.sv
module dcpg_datapath
    import dcpg_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dcpg_cmd_t               cmd,
    output dcpg_status_t            status,
    input  logic [NUMBER_WIDTH-1:0] number,
    output logic [NUMBER_WIDTH-1:0] number_echo,
    output logic [COUNT_W-1:0]      divisor_count,
    output logic                    is_prime,
    output logic [NUMBER_WIDTH-1:0] prime_gap
);

    // Trial divisor never passes floor(sqrt(2**NUMBER_WIDTH)) + 1.
    localparam int IW = (NUMBER_WIDTH + 1) / 2 + 1;
    localparam int SW = NUMBER_WIDTH + 2;

    logic [NUMBER_WIDTH-1:0] n_reg, n_next;
    logic [IW-1:0]           i_reg, i_next;
    logic [SW-1:0]           sq_reg, sq_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [NUMBER_WIDTH-1:0] prev_prime_reg, prev_prime_next;
    logic [NUMBER_WIDTH-1:0] echo_reg, echo_next;
    logic [COUNT_W-1:0]      dcount_reg, dcount_next;
    logic                    prime_reg, prime_next;
    logic [NUMBER_WIDTH-1:0] gap_reg, gap_next;
    logic [SW-1:0]           n_wide;
    logic [COUNT_W:0]        count_sum;
    logic                    rem_done;
    logic                    rem_zero;
    logic                    count_is_prime;

    dcpg_rem #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_rem),
        .dividend (n_reg),
        .divisor  ({{(NUMBER_WIDTH - IW){1'b0}}, i_reg}),
        .done     (rem_done),
        .rem_zero (rem_zero)
    );

    assign n_wide         = {2'b00, n_reg};
    assign count_is_prime = (count_reg == PRIME_COUNT);

    always_comb
    begin
        status.sq_le_n  = (sq_reg <= n_wide);
        status.rem_done = rem_done;

        // A divisor equal to the square root has no distinct partner.
        count_sum = {1'b0, count_reg} +
                    ((sq_reg == n_wide) ? {{COUNT_W{1'b0}}, 1'b1} : (COUNT_W + 1)'(2));

        n_next          = n_reg;
        i_next          = i_reg;
        sq_next         = sq_reg;
        count_next      = count_reg;
        prev_prime_next = prev_prime_reg;
        echo_next       = echo_reg;
        dcount_next     = dcount_reg;
        prime_next      = prime_reg;
        gap_next        = gap_reg;

        if (cmd.load)
        begin
            n_next     = number;
            i_next     = IW'(1);
            sq_next    = SW'(1);
            count_next = '0;
        end
        if (cmd.trial_update)
        begin
            if (rem_zero)
            begin
                count_next = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
            end
            i_next  = i_reg + IW'(1);
            // (i + 1)^2 = i^2 + 2i + 1
            sq_next = sq_reg + {{(SW - IW - 1){1'b0}}, i_reg, 1'b1};
        end
        if (cmd.out_load)
        begin
            echo_next   = n_reg;
            dcount_next = count_reg;
            prime_next  = count_is_prime;
            gap_next    = '0;
            if (count_is_prime)
            begin
                if (n_reg >= prev_prime_reg)
                begin
                    gap_next = n_reg - prev_prime_reg;
                end
                prev_prime_next = n_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_prime_reg <= NUMBER_WIDTH'(2);
        end
        else
        begin
            prev_prime_reg <= prev_prime_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        i_reg      <= i_next;
        sq_reg     <= sq_next;
        count_reg  <= count_next;
        echo_reg   <= echo_next;
        dcount_reg <= dcount_next;
        prime_reg  <= prime_next;
        gap_reg    <= gap_next;
    end

    assign number_echo   = echo_reg;
    assign divisor_count = dcount_reg;
    assign is_prime      = prime_reg;
    assign prime_gap     = gap_reg;

endmodule

### rtl/core/dcpg_ctrl.sv
module dcpg_ctrl
    import dcpg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  dcpg_status_t status,
    output dcpg_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // The output register can take a new word when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next       = state_reg;
        cmd.load         = 1'b0;
        cmd.start_rem    = 1'b0;
        cmd.trial_update = 1'b0;
        cmd.out_load     = 1'b0;
        in_ready         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.sq_le_n)
                begin
                    cmd.start_rem = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (status.rem_done)
                begin
                    cmd.trial_update = 1'b1;
                    state_next       = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/core/divisor_count_prime_gap.sv
// Channel   Handshake              Word
// input     in_valid / in_ready    number
// output    out_valid / out_ready  number_echo, divisor_count, is_prime, prime_gap
//
// One number is worked on at a time. Each trial divisor i = 1 .. floor(sqrt(n)) runs
// through the shared remainder unit (4 quotient bits a cycle) before the next is tried.
// Reset clears the controller and sets the stored prime to 2; there is no clearing pass.
// A stalled output word holds; the next number is taken while it waits.
module divisor_count_prime_gap
    import dcpg_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [NUMBER_WIDTH-1:0] number,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [NUMBER_WIDTH-1:0] number_echo,
    output logic [COUNT_W-1:0]      divisor_count,
    output logic                    is_prime,
    output logic [NUMBER_WIDTH-1:0] prime_gap
);

    dcpg_cmd_t    cmd;
    dcpg_status_t status;

    dcpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dcpg_datapath #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .number        (number),
        .number_echo   (number_echo),
        .divisor_count (divisor_count),
        .is_prime      (is_prime),
        .prime_gap     (prime_gap)
    );

    // Only one number is in flight, so an accepted word closes the input.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a number is in flight");

    a_prime_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_prime) |-> (divisor_count == PRIME_COUNT))
        else $error("prime flag without a divisor count of two");

    a_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_prime) |-> (prime_gap == '0))
        else $error("nonzero gap on a composite");

    a_load_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.out_load && (cmd.start_rem || cmd.trial_update || cmd.load)))
        else $error("output load overlaps trial work");

endmodule
